FILE: sv/rcm_pkg.sv
// rcm_pkg: shared types, codes and reset values for the cleaning robot
// motion controller. No dependencies; compiled first.
`timescale 1ns / 1ps

package rcm_pkg;

  // default width of the saturating tick counter
  localparam int unsigned TICK_WIDTH_DEF = 8;

  // configuration thresholds
  localparam int unsigned THRESH_W = 8;
  localparam logic [THRESH_W-1:0] TURN_TICKS_RST  = 8'd15;
  localparam logic [THRESH_W-1:0] BOOST_TICKS_RST = 8'd10;

  // apb register map: two 32-bit registers at byte offsets 0 and 4
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 3;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_TURN_TICKS  = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOOST_TICKS = 1'd1;

  // item kinds
  localparam logic CMD_SENSOR = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  typedef enum logic [2:0] {
    MOTOR_FWD   = 3'd0,
    MOTOR_LEFT  = 3'd1,
    MOTOR_RIGHT = 3'd2,
    MOTOR_BACK  = 3'd3,
    MOTOR_BOOST = 3'd4,
    MOTOR_STOP  = 3'd5
  } motor_e;

  typedef enum logic [1:0] {
    SUCTION_OFF   = 2'd0,
    SUCTION_ON    = 2'd1,
    SUCTION_BOOST = 2'd2
  } suction_e;

  typedef struct packed {
    logic dust;
    logic back;
    logic right;
    logic left;
    logic front;
  } flags_t;

  typedef struct packed {
    logic   cmd;
    flags_t flags;
  } item_t;

  typedef struct packed {
    motor_e   motor_mode;
    suction_e suction_mode;
    logic     mode_changed;
  } result_t;

  typedef struct packed {
    logic [THRESH_W-1:0] turn_ticks;
    logic [THRESH_W-1:0] boost_ticks;
  } cfg_t;

endpackage

FILE: sv/rcm_in_if.sv
// rcm_in_if: valid/ready channel carrying sensor updates and ticks.
// No dependencies.
`timescale 1ns / 1ps

interface rcm_in_if;
  logic valid;
  logic ready;
  logic cmd;
  logic obstacle_front;
  logic obstacle_left;
  logic obstacle_right;
  logic obstacle_back;
  logic dust_seen;

  modport source (
    output valid, cmd, obstacle_front, obstacle_left, obstacle_right,
           obstacle_back, dust_seen,
    input  ready
  );

  modport sink (
    input  valid, cmd, obstacle_front, obstacle_left, obstacle_right,
           obstacle_back, dust_seen,
    output ready
  );
endinterface

FILE: sv/rcm_out_if.sv
// rcm_out_if: valid/ready channel carrying motor and suction results.
// No dependencies.
`timescale 1ns / 1ps

interface rcm_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] motor_mode;
  logic [1:0] suction_mode;
  logic       mode_changed;

  modport source (
    output valid, motor_mode, suction_mode, mode_changed,
    input  ready
  );

  modport sink (
    input  valid, motor_mode, suction_mode, mode_changed,
    output ready
  );
endinterface

FILE: sv/robot_cleaner_motion_fsm_top.sv
// robot_cleaner_motion_fsm_top: cleaning robot motion controller top level.
// Depends on rcm_pkg, rcm_in_if, rcm_out_if, rcm_cfg and rcm_core.
`timescale 1ns / 1ps

// Usage
//   in_i  : valid/ready channel, one transaction per sensor update (cmd 0)
//           or controller tick (cmd 1).
//   out_o : valid/ready channel, exactly one result per input transaction,
//           in order: motor mode, suction mode, and whether the motor mode
//           changed.
//   apb   : register 0 at offset 0 is turn_ticks, register 1 at offset 4 is
//           boost_ticks; write only while no transaction is in flight.
// Results are registered in the result register, or the skid register while
// one is held. One transaction per cycle when in_i.ready is high; the state
// update is a single level of mode logic plus the tick counter increment.
// A two-entry output buffer (result register plus skid register) lets input
// be taken while one result waits; in_i.ready drops only when both entries
// are full, i.e. after the receiver has stalled two results.
// Reset puts the motor in forward, suction on, counter and sensor flags to
// zero, thresholds to 15 and 10, and empties the output buffer.

module robot_cleaner_motion_fsm_top #(
  parameter int unsigned TICK_WIDTH = rcm_pkg::TICK_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rcm_in_if.sink                      in_i,
  rcm_out_if.source                   out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcm_pkg::ADDR_W-1:0]  paddr,
  input  logic [rcm_pkg::DATA_W-1:0]  pwdata,
  output logic [rcm_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import rcm_pkg::*;

  cfg_t    cfg;
  item_t   item;
  result_t res;
  logic    accept;

  result_t out_q, out_d, skid_q, skid_d;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  assign pready = 1'b1;

  rcm_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .cfg_o     (cfg)
  );

  // input transaction
  assign in_i.ready  = !skid_valid_q;
  assign accept      = in_i.valid && in_i.ready;
  assign item.cmd    = in_i.cmd;
  assign item.flags  = '{dust:  in_i.dust_seen,
                         back:  in_i.obstacle_back,
                         right: in_i.obstacle_right,
                         left:  in_i.obstacle_left,
                         front: in_i.obstacle_front};

  rcm_core #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .cfg_i    (cfg),
    .result_o (res)
  );

  // output buffer: result register with skid entry behind it
  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (out_valid_q && !out_o.ready) begin
      if (accept) begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (skid_valid_q) begin
      out_d        = skid_q;
      out_valid_d  = 1'b1;
      skid_d       = res;
      skid_valid_d = accept;
    end else begin
      out_d       = res;
      out_valid_d = accept;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.motor_mode   = out_q.motor_mode;
  assign out_o.suction_mode = out_q.suction_mode;
  assign out_o.mode_changed = out_q.mode_changed;

  // skid entry is only used behind a held result
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full with result register empty");

  // a transaction into an empty buffer shows up next cycle
  a_accept_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !out_valid_q |=> out_valid_q && !skid_valid_q)
    else $error("accepted transaction not presented");

  // a taken result with a waiting skid entry refills the result register
  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && out_o.ready |=> out_valid_q)
    else $error("skid entry lost");

endmodule

FILE: sv/rcm_cfg.sv
// rcm_cfg: apb register file holding the turn and boost tick thresholds.
// Depends on rcm_pkg.
`timescale 1ns / 1ps

module rcm_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel_i,
  input  logic                         penable_i,
  input  logic                         pwrite_i,
  input  logic [rcm_pkg::ADDR_W-1:0]   paddr_i,
  input  logic [rcm_pkg::DATA_W-1:0]   pwdata_i,
  output logic [rcm_pkg::DATA_W-1:0]   prdata_o,
  output rcm_pkg::cfg_t                cfg_o
);
  import rcm_pkg::*;

  logic [REG_IDX_W-1:0] idx;
  logic                 wr_en;
  cfg_t                 cfg_q, cfg_d;

  // register index from the word address, byte lanes ignored
  assign idx   = paddr_i[ADDR_W-1 -: REG_IDX_W];
  assign wr_en = psel_i && penable_i && pwrite_i;

  // write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_TURN_TICKS:  cfg_d.turn_ticks  = pwdata_i[THRESH_W-1:0];
        REG_BOOST_TICKS: cfg_d.boost_ticks = pwdata_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.turn_ticks  <= TURN_TICKS_RST;
      cfg_q.boost_ticks <= BOOST_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_TURN_TICKS:  prdata_o = {{(DATA_W-THRESH_W){1'b0}}, cfg_q.turn_ticks};
      REG_BOOST_TICKS: prdata_o = {{(DATA_W-THRESH_W){1'b0}}, cfg_q.boost_ticks};
      default:         prdata_o = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

FILE: sv/rcm_core.sv
// rcm_core: motion/suction state, tick counter and sensor latch, stepped
// once per accepted transaction. Depends on rcm_pkg.
`timescale 1ns / 1ps

module rcm_core #(
  parameter int unsigned TICK_WIDTH = rcm_pkg::TICK_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  rcm_pkg::item_t    item_i,
  input  rcm_pkg::cfg_t     cfg_i,
  output rcm_pkg::result_t  result_o
);
  import rcm_pkg::*;

  // compare width covers both counter and threshold
  localparam int unsigned CmpW = (TICK_WIDTH > THRESH_W) ? TICK_WIDTH : THRESH_W;

  motor_e                motion_q, motion_d;
  suction_e              suction_q, suction_d;
  logic [TICK_WIDTH-1:0] cnt_q, cnt_d, cnt_inc;
  flags_t                latch_q, latch_d;
  logic                  turn_done, boost_done;

  // saturating increment and threshold checks
  assign cnt_inc    = (&cnt_q) ? cnt_q : cnt_q + 1'b1;
  assign turn_done  = CmpW'(cnt_inc) >= CmpW'(cfg_i.turn_ticks);
  assign boost_done = CmpW'(cnt_inc) >= CmpW'(cfg_i.boost_ticks);

  // next state
  always_comb begin
    motion_d  = motion_q;
    suction_d = suction_q;
    cnt_d     = cnt_q;
    latch_d   = latch_q;
    if (accept_i) begin
      if (item_i.cmd == CMD_SENSOR) begin
        latch_d = item_i.flags;
      end else begin
        cnt_d = cnt_inc;
        case (motion_q)
          MOTOR_FWD: begin
            if (latch_q.front) begin
              if (!latch_q.left) begin
                cnt_d    = '0;
                motion_d = MOTOR_LEFT;
              end else if (!latch_q.right) begin
                cnt_d    = '0;
                motion_d = MOTOR_RIGHT;
              end else begin
                motion_d = MOTOR_BACK;
              end
              suction_d = SUCTION_OFF;
            end else if (latch_q.dust) begin
              cnt_d     = '0;
              motion_d  = MOTOR_BOOST;
              suction_d = SUCTION_BOOST;
            end
          end
          MOTOR_LEFT, MOTOR_RIGHT: begin
            if (turn_done) begin
              motion_d      = MOTOR_FWD;
              suction_d     = SUCTION_ON;
              latch_d.front = 1'b0;
              cnt_d         = '0;
            end
          end
          MOTOR_BACK: begin
            if (!latch_q.left && !latch_q.right) begin
              motion_d = MOTOR_LEFT;
            end else if (latch_q.left && !latch_q.right) begin
              motion_d = MOTOR_RIGHT;
            end else if (latch_q.back && latch_q.left && latch_q.right) begin
              motion_d = MOTOR_STOP;
            end
          end
          MOTOR_BOOST: begin
            if (latch_q.front || boost_done) begin
              motion_d  = MOTOR_FWD;
              suction_d = SUCTION_ON;
              cnt_d     = '0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_q  <= MOTOR_FWD;
      suction_q <= SUCTION_ON;
      cnt_q     <= '0;
      latch_q   <= '0;
    end else begin
      motion_q  <= motion_d;
      suction_q <= suction_d;
      cnt_q     <= cnt_d;
      latch_q   <= latch_d;
    end
  end

  // result for this transaction
  always_comb begin
    result_o.motor_mode   = motion_d;
    result_o.suction_mode = suction_d;
    result_o.mode_changed = (motion_d != motion_q);
  end

  // stop is left only through reset
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    motion_q == MOTOR_STOP |=> motion_q == MOTOR_STOP)
    else $error("stop mode was left");

  // forward always runs with suction on, boost with suction boost
  a_fwd_suction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    motion_q == MOTOR_FWD |-> suction_q == SUCTION_ON)
    else $error("forward without suction on");

  a_boost_suction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    motion_q == MOTOR_BOOST |-> suction_q == SUCTION_BOOST)
    else $error("boost without suction boost");

  // a sensor update never moves the motor mode
  a_sensor_keeps_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && item_i.cmd == CMD_SENSOR |=> $stable(motion_q))
    else $error("sensor update changed motor mode");

endmodule

FILE: tb/robot_cleaner_motion_fsm_top_test.sv
// robot_cleaner_motion_fsm_top_test: self-checking bench for the cleaning robot
// motion controller; a scoreboard class predicts every result in order.
// Depends on rcm_pkg, rcm_in_if, rcm_out_if and robot_cleaner_motion_fsm_top.
`timescale 1ns / 1ps

module robot_cleaner_motion_fsm_top_test;
  import rcm_pkg::*;

  localparam int unsigned TICK_W = TICK_WIDTH_DEF;

  // motion and suction predictor with its queue of expected results
  class motion_scoreboard;
    motor_e              motion;
    suction_e            suction;
    logic [TICK_W-1:0]   ticks;
    flags_t              latch;
    logic [THRESH_W-1:0] turn_lim;
    logic [THRESH_W-1:0] boost_lim;
    result_t             expected_q[$];
    int                  errors;

    function new();
      motion    = MOTOR_FWD;
      suction   = SUCTION_ON;
      ticks     = '0;
      latch     = '0;
      turn_lim  = TURN_TICKS_RST;
      boost_lim = BOOST_TICKS_RST;
      errors    = 0;
    endfunction

    function void set_limits(logic [THRESH_W-1:0] turn, logic [THRESH_W-1:0] boost);
      turn_lim  = turn;
      boost_lim = boost;
    endfunction

    // one controller tick: saturating count, then the mode step
    function void advance_tick();
      if (ticks != '1) ticks = ticks + 1'b1;
      case (motion)
        MOTOR_FWD: begin
          if (latch.front) begin
            if (!latch.left) begin
              ticks  = '0;
              motion = MOTOR_LEFT;
            end else if (!latch.right) begin
              ticks  = '0;
              motion = MOTOR_RIGHT;
            end else begin
              motion = MOTOR_BACK;
            end
            suction = SUCTION_OFF;
          end else if (latch.dust) begin
            ticks   = '0;
            motion  = MOTOR_BOOST;
            suction = SUCTION_BOOST;
          end
        end
        MOTOR_LEFT, MOTOR_RIGHT: begin
          if (ticks >= turn_lim) begin
            motion      = MOTOR_FWD;
            suction     = SUCTION_ON;
            latch.front = 1'b0;
            ticks       = '0;
          end
        end
        MOTOR_BACK: begin
          if (!latch.left && !latch.right) motion = MOTOR_LEFT;
          else if (latch.left && !latch.right) motion = MOTOR_RIGHT;
          else if (latch.back && latch.left && latch.right) motion = MOTOR_STOP;
        end
        MOTOR_BOOST: begin
          if (latch.front || ticks >= boost_lim) begin
            motion  = MOTOR_FWD;
            suction = SUCTION_ON;
            ticks   = '0;
          end
        end
        default: begin
        end
      endcase
    endfunction

    // accepted input transaction: update state, queue the expected result
    function void note_item(item_t it);
      motor_e  prior;
      result_t r;
      prior = motion;
      if (it.cmd == CMD_SENSOR) latch = it.flags;
      else advance_tick();
      r.motor_mode   = motion;
      r.suction_mode = suction;
      r.mode_changed = (motion != prior);
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // accepted output transaction against the oldest expectation
    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result motor %0d suction %0d changed %0b",
                         got.motor_mode, got.suction_mode, got.mode_changed));
        return;
      end
      want = expected_q.pop_front();
      if (got.motor_mode !== want.motor_mode)
        report($sformatf("motor_mode got %0d want %0d", got.motor_mode, want.motor_mode));
      if (got.suction_mode !== want.suction_mode)
        report($sformatf("suction_mode got %0d want %0d",
                         got.suction_mode, want.suction_mode));
      if (got.mode_changed !== want.mode_changed)
        report($sformatf("mode_changed got %0b want %0b",
                         got.mode_changed, want.mode_changed));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  rcm_in_if  in_if ();
  rcm_out_if out_if ();

  motion_scoreboard sb = new();

  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold_req;

  robot_cleaner_motion_fsm_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random ready, plus long hold-offs on request
  initial begin
    int hold;
    hold = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req > 0) begin
        hold        = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // output monitor
  initial begin
    result_t got;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        got.motor_mode   = motor_e'(out_if.motor_mode);
        got.suction_mode = suction_e'(out_if.suction_mode);
        got.mode_changed = out_if.mode_changed;
        sb.check_result(got);
      end
    end
  end

  function automatic item_t sensor_item(bit f, bit l, bit r, bit b, bit d);
    item_t it;
    it.cmd         = CMD_SENSOR;
    it.flags.front = f;
    it.flags.left  = l;
    it.flags.right = r;
    it.flags.back  = b;
    it.flags.dust  = d;
    return it;
  endfunction

  // tick payload flags are ignored by the block, so they stay random
  function automatic item_t tick_item();
    item_t it;
    it.cmd   = CMD_TICK;
    it.flags = 5'($urandom_range(31));
    return it;
  endfunction

  // mostly ticks with biased sensor flags, some fully random flags;
  // back+left+right is never latched so the run does not end in stop early
  function automatic item_t random_item();
    item_t it;
    it.cmd = ($urandom_range(99) < 65) ? CMD_TICK : CMD_SENSOR;
    if ($urandom_range(99) < 20) begin
      it.flags = 5'($urandom_range(31));
    end else begin
      it.flags.front = ($urandom_range(99) < 35);
      it.flags.left  = ($urandom_range(99) < 40);
      it.flags.right = ($urandom_range(99) < 40);
      it.flags.back  = ($urandom_range(99) < 30);
      it.flags.dust  = ($urandom_range(99) < 25);
    end
    if (it.cmd == CMD_SENSOR && it.flags.back && it.flags.left && it.flags.right)
      it.flags.back = 1'b0;
    return it;
  endfunction

  // offer one input transaction; entered and left at a falling edge
  task automatic send_item(item_t it);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.cmd            <= it.cmd;
    in_if.obstacle_front <= it.flags.front;
    in_if.obstacle_left  <= it.flags.left;
    in_if.obstacle_right <= it.flags.right;
    in_if.obstacle_back  <= it.flags.back;
    in_if.dust_seen      <= it.flags.dust;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_item(it);
    @(negedge clk_i);
  endtask

  // hold the input until every expected result has come back
  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one apb transfer: setup cycle, access cycle, then psel and penable drop
  task automatic apb_access(bit wr, logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // program both thresholds while idle, then read them back
  task automatic program_limits(logic [THRESH_W-1:0] turn, logic [THRESH_W-1:0] boost);
    logic [DATA_W-1:0] rd;
    drain_results();
    apb_access(1'b1, REG_TURN_TICKS, {24'($urandom), turn}, rd);
    apb_access(1'b1, REG_BOOST_TICKS, {24'($urandom), boost}, rd);
    sb.set_limits(turn, boost);
    apb_access(1'b0, REG_TURN_TICKS, '0, rd);
    if (rd[THRESH_W-1:0] !== turn)
      sb.report($sformatf("turn_ticks read %0d want %0d", rd[THRESH_W-1:0], turn));
    apb_access(1'b0, REG_BOOST_TICKS, '0, rd);
    if (rd[THRESH_W-1:0] !== boost)
      sb.report($sformatf("boost_ticks read %0d want %0d", rd[THRESH_W-1:0], boost));
  endtask

  // stimulus
  initial begin
    logic [THRESH_W-1:0] turn_tab [6];
    logic [THRESH_W-1:0] boost_tab [6];
    turn_tab  = '{8'd15, 8'd0, 8'd255, 8'd3, 8'd0, 8'd1};
    boost_tab = '{8'd10, 8'd0, 8'd255, 8'd5, 8'd0, 8'd200};

    tx_idle_pct          = 31;
    rx_idle_pct          = 71;
    rx_hold_req          = 0;
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_if.valid          = 1'b0;
    in_if.cmd            = CMD_SENSOR;
    in_if.obstacle_front = 1'b0;
    in_if.obstacle_left  = 1'b0;
    in_if.obstacle_right = 1'b0;
    in_if.obstacle_back  = 1'b0;
    in_if.dust_seen      = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed part at the reset thresholds
    send_item(sensor_item(0, 0, 0, 0, 0));
    send_item(tick_item());
    send_item(sensor_item(1, 1, 1, 1, 1));
    send_item(sensor_item(0, 0, 0, 0, 1));
    send_item(tick_item());                   // forward to boost
    send_item(sensor_item(1, 0, 0, 0, 0));
    send_item(tick_item());                   // boost ends on front obstacle
    send_item(sensor_item(1, 1, 1, 0, 0));
    send_item(tick_item());                   // boxed in: backward
    send_item(tick_item());                   // left and right blocked: stays
    send_item(sensor_item(0, 0, 1, 0, 0));
    send_item(tick_item());                   // right only blocked: stays
    send_item(sensor_item(0, 1, 0, 0, 0));
    send_item(tick_item());                   // backward to turn right
    repeat (11) send_item(tick_item());       // turn ends at default limit

    // counter saturation: a turn entered from backward at full count
    program_limits(8'd255, 8'd200);
    send_item(sensor_item(0, 0, 0, 0, 0));
    repeat (260) send_item(tick_item());
    send_item(sensor_item(1, 1, 1, 0, 0));
    send_item(tick_item());
    send_item(sensor_item(0, 0, 0, 0, 0));
    send_item(tick_item());
    send_item(tick_item());

    // random phases over several threshold settings and idling regimes
    for (int p = 0; p < 6; p++) begin
      if (p == 4) begin
        turn_tab[p]  = THRESH_W'($urandom_range(1, 40));
        boost_tab[p] = THRESH_W'($urandom_range(1, 40));
      end
      program_limits(turn_tab[p], boost_tab[p]);
      case (p / 2)
        0: begin
          tx_idle_pct = 31;
          rx_idle_pct = 71;
        end
        1: begin
          tx_idle_pct = 71;
          rx_idle_pct = 31;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < 190; n++) begin
        if (n == 60) rx_hold_req = 120;
        if (n == 150) drain_results();
        send_item(random_item());
      end
    end

    // stop: steer into it with zero limits, then it must hold
    program_limits(8'd0, 8'd0);
    while (sb.motion != MOTOR_STOP) begin
      case (sb.motion)
        MOTOR_FWD: begin
          send_item(sensor_item(1, 1, 1, 0, 0));
        end
        MOTOR_BACK: begin
          send_item(sensor_item(0, 1, 1, 1, 0));
        end
        default: begin
        end
      endcase
      send_item(tick_item());
    end
    repeat (5) send_item(tick_item());
    send_item(sensor_item(0, 0, 0, 0, 1));
    send_item(tick_item());
    send_item(sensor_item(1, 0, 0, 0, 0));
    send_item(tick_item());

    // wind down
    drain_results();
    repeat (8) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d expected results never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/rcm_pkg.sv
sv/rcm_in_if.sv
sv/rcm_out_if.sv
sv/rcm_cfg.sv
sv/rcm_core.sv
sv/robot_cleaner_motion_fsm_top.sv
tb/robot_cleaner_motion_fsm_top_test.sv
